FILE: rtl/core/gimli_pkg.sv
// Gimli permutation package: state types, round constants, controller states.
// Used by every file of the block; depends on nothing.
package gimli_pkg;

    localparam int NUM_WORDS   = 12;
    localparam int WORD_W      = 32;
    localparam int ROUND_COUNT = 24;
    localparam int ROUND_W     = $clog2(ROUND_COUNT + 1);

    localparam logic [WORD_W-1:0] ROUND_CONST = 32'h9e377900;

    localparam logic [1:0] PHASE_SMALL_SWAP = 2'd0;
    localparam logic [1:0] PHASE_BIG_SWAP   = 2'd2;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;
    typedef logic [ROUND_W-1:0] round_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic   load;
        logic   step;
        logic   store;
        round_t round;
    } dp_cmd_t;

endpackage

FILE: rtl/core/gimli_if.sv
// Valid/ready channel interfaces for the Gimli block: input state and result.
// Depends on gimli_pkg.
interface gimli_in_if;
    import gimli_pkg::*;

    logic  valid;
    logic  ready;
    word_t word_0;
    word_t word_1;
    word_t word_2;
    word_t word_3;
    word_t word_4;
    word_t word_5;
    word_t word_6;
    word_t word_7;
    word_t word_8;
    word_t word_9;
    word_t word_10;
    word_t word_11;

    modport source (
        output valid, word_0, word_1, word_2, word_3, word_4, word_5,
               word_6, word_7, word_8, word_9, word_10, word_11,
        input  ready
    );
    modport sink (
        input  valid, word_0, word_1, word_2, word_3, word_4, word_5,
               word_6, word_7, word_8, word_9, word_10, word_11,
        output ready
    );
endinterface

interface gimli_out_if;
    import gimli_pkg::*;

    logic  valid;
    logic  ready;
    word_t out_0;
    word_t out_1;
    word_t out_2;
    word_t out_3;
    word_t out_4;
    word_t out_5;
    word_t out_6;
    word_t out_7;
    word_t out_8;
    word_t out_9;
    word_t out_10;
    word_t out_11;

    modport source (
        output valid, out_0, out_1, out_2, out_3, out_4, out_5,
               out_6, out_7, out_8, out_9, out_10, out_11,
        input  ready
    );
    modport sink (
        input  valid, out_0, out_1, out_2, out_3, out_4, out_5,
               out_6, out_7, out_8, out_9, out_10, out_11,
        output ready
    );
endinterface

FILE: rtl/core/gimli_permutation_unit.sv
// Gimli permutation unit, top level: joins controller and datapath to the channels.
// Depends on gimli_pkg, gimli_if, gimli_ctrl, gimli_dp.
//
// Usage:
//   in_ch  (sink)   carries a 384-bit state as word_0..word_11 (row-major,
//                   word = 4*row + column). A transaction is taken when
//                   valid and ready are both high; ready is high only while
//                   the round loop is idle.
//   out_ch (source) carries the permuted state as out_0..out_11 from a
//                   separate output register.
// Rounds: after the input transaction the state register runs 24 rounds,
//   one round per cycle (four column SP-boxes in parallel plus the
//   swap/constant stage); the result then moves into the output register,
//   which raises out_ch.valid.
// Occupancy: one permutation at a time in the round loop; the next input is
//   accepted only after the 24 rounds, the move into the output register and
//   a return to idle.
// Stall: the result waits in the output register with valid held high until
//   out_ch.ready is seen; the round loop meanwhile takes and runs the next
//   input, and holds its own finished result (input blocked) only while the
//   output register is still full.
// Reset: rst_n (async, active low) returns the controller to idle and clears
//   out_ch.valid; the state and output registers are not reset.
module gimli_permutation_unit (
    input logic       clk,
    input logic       rst_n,
    gimli_in_if.sink  in_ch,
    gimli_out_if.source out_ch
);
    import gimli_pkg::*;

    dp_cmd_t cmd;
    state_t  load_state;
    state_t  state;

    assign load_state[0]  = in_ch.word_0;
    assign load_state[1]  = in_ch.word_1;
    assign load_state[2]  = in_ch.word_2;
    assign load_state[3]  = in_ch.word_3;
    assign load_state[4]  = in_ch.word_4;
    assign load_state[5]  = in_ch.word_5;
    assign load_state[6]  = in_ch.word_6;
    assign load_state[7]  = in_ch.word_7;
    assign load_state[8]  = in_ch.word_8;
    assign load_state[9]  = in_ch.word_9;
    assign load_state[10] = in_ch.word_10;
    assign load_state[11] = in_ch.word_11;

    // sequencing: idle -> 24 rounds -> hand result to the output register
    gimli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // state register for the rounds, output register for the result
    gimli_dp u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .load_state (load_state),
        .state      (state)
    );

    assign out_ch.out_0  = state[0];
    assign out_ch.out_1  = state[1];
    assign out_ch.out_2  = state[2];
    assign out_ch.out_3  = state[3];
    assign out_ch.out_4  = state[4];
    assign out_ch.out_5  = state[5];
    assign out_ch.out_6  = state[6];
    assign out_ch.out_7  = state[7];
    assign out_ch.out_8  = state[8];
    assign out_ch.out_9  = state[9];
    assign out_ch.out_10 = state[10];
    assign out_ch.out_11 = state[11];

endmodule

FILE: rtl/core/gimli_ctrl.sv
// Gimli controller: handshake state machine and round counter.
// Depends on gimli_pkg.
module gimli_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output gimli_pkg::dp_cmd_t cmd
);
    import gimli_pkg::*;

    ctrl_state_t state_reg, state_next;
    round_t      round_reg, round_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    // output register empty, or emptied at this edge
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state, round count and output valid
    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    round_next = round_t'(ROUND_COUNT);
                end
            end
            ST_RUN:
            begin
                round_next = round_reg - round_t'(1);
                if (round_reg == round_t'(1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = out_valid_reg;
        cmd.load  = 1'b0;
        cmd.step  = 1'b0;
        cmd.store = 1'b0;
        cmd.round = round_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.store = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/gimli_dp.sv
// Gimli datapath: 384-bit state register, one full round per step, output register.
// Depends on gimli_pkg.
module gimli_dp (
    input  logic                clk,
    input  gimli_pkg::dp_cmd_t  cmd,
    input  gimli_pkg::state_t   load_state,
    output gimli_pkg::state_t   state
);
    import gimli_pkg::*;

    state_t state_reg, state_next;
    state_t out_reg, out_next;
    state_t sp_out;
    state_t round_out;

    // four column SP-boxes side by side
    always_comb
    begin
        word_t x, y, z;
        sp_out = state_reg;
        for (int c = 0; c < 4; c++)
        begin
            x = {state_reg[c][7:0], state_reg[c][31:8]};
            y = {state_reg[c+4][22:0], state_reg[c+4][31:23]};
            z = state_reg[c+8];
            sp_out[c+8] = x ^ (z << 1) ^ ((y & z) << 2);
            sp_out[c+4] = y ^ x ^ ((x | z) << 1);
            sp_out[c]   = z ^ y ^ ((x & y) << 3);
        end
    end

    // swaps and round constant
    always_comb
    begin
        round_out = sp_out;
        case (cmd.round[1:0])
            PHASE_SMALL_SWAP:
            begin
                round_out[0] = sp_out[1] ^ ROUND_CONST
                             ^ {{(WORD_W-ROUND_W){1'b0}}, cmd.round};
                round_out[1] = sp_out[0];
                round_out[2] = sp_out[3];
                round_out[3] = sp_out[2];
            end
            PHASE_BIG_SWAP:
            begin
                round_out[0] = sp_out[2];
                round_out[1] = sp_out[3];
                round_out[2] = sp_out[0];
                round_out[3] = sp_out[1];
            end
            default:
            begin
                round_out = sp_out;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        if (cmd.load)
            state_next = load_state;
        else if (cmd.step)
            state_next = round_out;
    end

    // finished state moves here so the round loop can take the next input
    always_comb
    begin
        out_next = out_reg;
        if (cmd.store)
            out_next = state_reg;
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        out_reg   <= out_next;
    end

    assign state = out_reg;

endmodule

FILE: test/tb.sv
// Testbench for gimli_permutation_unit: drives 384-bit states and checks each permuted result.
// Depends on gimli_pkg, gimli_in_if / gimli_out_if and the RTL of the unit.
module tb;
    import gimli_pkg::*;

    logic clk;
    logic rst_n;

    gimli_in_if  in_ch ();
    gimli_out_if out_ch ();

    gimli_permutation_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // permuted states still owed by the unit, oldest first
    state_t pending_perms[$];
    int     mismatch_count;
    // random gaps on both channels on/off
    bit     idle_on;
    int     rx_stall;

    // ------------------------------------------------------------------
    // Predictor: full Gimli permutation, rounds ROUND_COUNT down to 1.
    // Word index is 4*row + column, same as the channel fields.
    // ------------------------------------------------------------------
    function automatic state_t gimli_permute(state_t s);
        word_t      x;
        word_t      y;
        word_t      z;
        word_t      t;
        logic [1:0] phase;
        for (int r = ROUND_COUNT; r > 0; r--) begin
            // column SP-boxes
            for (int c = 0; c < 4; c++) begin
                x = {s[c][7:0], s[c][31:8]};        // rotl 24
                y = {s[c+4][22:0], s[c+4][31:23]};  // rotl 9
                z = s[c+8];
                s[c+8] = x ^ (z << 1) ^ ((y & z) << 2);
                s[c+4] = y ^ x ^ ((x | z) << 1);
                s[c]   = z ^ y ^ ((x & y) << 3);
            end
            phase = r[1:0];
            if (phase == PHASE_SMALL_SWAP) begin
                t = s[0]; s[0] = s[1]; s[1] = t;
                t = s[2]; s[2] = s[3]; s[3] = t;
            end
            if (phase == PHASE_BIG_SWAP) begin
                t = s[0]; s[0] = s[2]; s[2] = t;
                t = s[1]; s[1] = s[3]; s[3] = t;
            end
            // round constant goes in after the small swap
            if (phase == PHASE_SMALL_SWAP)
                s[0] = s[0] ^ (ROUND_CONST | word_t'(r));
        end
        return s;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // random state; some words forced to edge patterns so the extremes
    // keep turning up inside the random part too
    function automatic state_t random_state();
        state_t s;
        int     roll;
        for (int i = 0; i < NUM_WORDS; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
                s[i] = $urandom();
            else if (roll < 82)
                s[i] = '0;
            else if (roll < 89)
                s[i] = '1;
            else if (roll < 95)
                s[i] = word_t'(1) << $urandom_range(0, WORD_W - 1);
            else
                s[i] = ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset. Reset is asserted at the start and released once.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Input side. Inputs move on the falling edge; a transaction is
    // taken at a rising edge with valid and ready high. valid is left
    // high after a transaction so back-to-back sends never drop it; the
    // next send or the end of stimulus decides whether it falls.
    // ------------------------------------------------------------------
    task automatic send_state(state_t s);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.word_0  = s[0];
        in_ch.word_1  = s[1];
        in_ch.word_2  = s[2];
        in_ch.word_3  = s[3];
        in_ch.word_4  = s[4];
        in_ch.word_5  = s[5];
        in_ch.word_6  = s[6];
        in_ch.word_7  = s[7];
        in_ch.word_8  = s[8];
        in_ch.word_9  = s[9];
        in_ch.word_10 = s[10];
        in_ch.word_11 = s[11];
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_perms.push_back(gimli_permute(s));
    endtask

    // ------------------------------------------------------------------
    // Output side. ready is driven on the falling edge: a stall is drawn
    // after each result transaction, and occasionally one starts on its
    // own so that stalls also land while the rounds are still running.
    // ------------------------------------------------------------------
    initial
    begin
        rx_stall = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_stall == 0 && idle_on && $urandom_range(0, 15) == 0)
                rx_stall = pick_gap();
            if (rx_stall > 0)
            begin
                out_ch.ready = 1'b0;
                rx_stall--;
            end
            else
                out_ch.ready = 1'b1;
        end
    end

    // Result check: every result transaction against the oldest
    // expectation, word by word.
    always @(posedge clk)
    begin
        state_t got;
        state_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = {out_ch.out_11, out_ch.out_10, out_ch.out_9, out_ch.out_8,
                   out_ch.out_7,  out_ch.out_6,  out_ch.out_5, out_ch.out_4,
                   out_ch.out_3,  out_ch.out_2,  out_ch.out_1, out_ch.out_0};
            if (pending_perms.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction: %h", got);
            end
            else
            begin
                want = pending_perms.pop_front();
                for (int i = 0; i < NUM_WORDS; i++)
                    if (got[i] !== want[i])
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("out_%0d mismatch: expected %h, got %h",
                                     i, want[i], got[i]);
                    end
            end
            rx_stall = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Edge patterns: all zero, all ones, alternating bits, lone MSB/LSB,
    // each word saturated on its own to catch row/column mixups, then a ramp with a distinct value in each word.
    task automatic test_directed();
        state_t s;
        idle_on = 1'b0;
        send_state('0);
        send_state('1);
        send_state({NUM_WORDS{32'haaaaaaaa}});
        send_state({NUM_WORDS{32'h55555555}});
        send_state({NUM_WORDS{32'h80000000}});
        send_state({NUM_WORDS{32'h00000001}});
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            s = '0;
            s[i] = '1;
            send_state(s);
        end
        for (int i = 0; i < NUM_WORDS; i++)
            s[i] = word_t'(i) * 32'h11111111;
        send_state(s);
    endtask

    // Back-to-back: no input gaps, output side always ready.
    task automatic test_streaming();
        idle_on = 1'b0;
        repeat (150) send_state(random_state());
    endtask

    // Random gaps on input and output.
    task automatic test_gaps();
        idle_on = 1'b1;
        repeat (500) send_state(random_state());
    endtask

    // Gaps on, then a burst with none, then gaps again.
    task automatic test_mixed();
        idle_on = 1'b1;
        repeat (50) send_state(random_state());
        idle_on = 1'b0;
        repeat (50) send_state(random_state());
        idle_on = 1'b1;
        repeat (50) send_state(random_state());
    endtask

    initial
    begin
        mismatch_count = 0;
        idle_on        = 1'b0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.word_0   = '0;
        in_ch.word_1   = '0;
        in_ch.word_2   = '0;
        in_ch.word_3   = '0;
        in_ch.word_4   = '0;
        in_ch.word_5   = '0;
        in_ch.word_6   = '0;
        in_ch.word_7   = '0;
        in_ch.word_8   = '0;
        in_ch.word_9   = '0;
        in_ch.word_10  = '0;
        in_ch.word_11  = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_streaming();
        test_gaps();
        test_mixed();

        @(negedge clk);
        in_ch.valid = 1'b0;
        wait (pending_perms.size() == 0);
        // let any stray result show up before the verdict
        repeat (60) @(posedge clk);

        if (mismatch_count == 0 && pending_perms.size() == 0)
            $display("** gimli_permutation_unit: PASSED **");
        else
            $display("** gimli_permutation_unit: FAILED **");
        $finish;
    end

    // Watchdog, set far above the slowest legal run.
    initial
    begin
        #5000000;
        $display("** gimli_permutation_unit: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/gimli_pkg.sv
rtl/core/gimli_if.sv
rtl/core/gimli_ctrl.sv
rtl/core/gimli_dp.sv
rtl/core/gimli_permutation_unit.sv
test/tb.sv
